[hdl/drrc_pkg.sv]
// types, tables and bit functions shared by the reduced-round cipher
`default_nettype none
package drrc_pkg;

  // payload carried from stage to stage: data halves and key halves
  typedef struct packed {
    logic [63:0] lr;
    logic [55:0] cd;
  } stage_t;

  // configuration seen by the entry and round stages, round count already clamped
  typedef struct packed {
    logic [4:0] rounds;
    logic       rev;
    logic       pinv;
  } cfg_t;

  // configuration register indexes
  localparam logic [1:0] REG_ROUNDS = 2'd0;
  localparam logic [1:0] REG_REV    = 2'd1;
  localparam logic [1:0] REG_PINV   = 2'd2;

  localparam logic [1:0] ROT [16] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1};

  localparam logic [6:0] PC2 [48] = '{
    7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
    7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
    7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
    7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32};

  localparam logic [6:0] IP [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};

  localparam logic [6:0] FP [64] = '{
    7'd8, 7'd40, 7'd16, 7'd48, 7'd24, 7'd56, 7'd32, 7'd64,
    7'd7, 7'd39, 7'd15, 7'd47, 7'd23, 7'd55, 7'd31, 7'd63,
    7'd6, 7'd38, 7'd14, 7'd46, 7'd22, 7'd54, 7'd30, 7'd62,
    7'd5, 7'd37, 7'd13, 7'd45, 7'd21, 7'd53, 7'd29, 7'd61,
    7'd4, 7'd36, 7'd12, 7'd44, 7'd20, 7'd52, 7'd28, 7'd60,
    7'd3, 7'd35, 7'd11, 7'd43, 7'd19, 7'd51, 7'd27, 7'd59,
    7'd2, 7'd34, 7'd10, 7'd42, 7'd18, 7'd50, 7'd26, 7'd58,
    7'd1, 7'd33, 7'd9,  7'd41, 7'd17, 7'd49, 7'd25, 7'd57};

  localparam logic [6:0] EXP [48] = '{
    7'd32, 7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,
    7'd8,  7'd9,  7'd10, 7'd11, 7'd12, 7'd13, 7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17,
    7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25,
    7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29, 7'd28, 7'd29, 7'd30, 7'd31, 7'd32, 7'd1};

  localparam logic [6:0] PT [32] = '{
    7'd16, 7'd7,  7'd20, 7'd21, 7'd29, 7'd12, 7'd28, 7'd17,
    7'd1,  7'd15, 7'd23, 7'd26, 7'd5,  7'd18, 7'd31, 7'd10,
    7'd2,  7'd8,  7'd24, 7'd14, 7'd32, 7'd27, 7'd3,  7'd9,
    7'd19, 7'd13, 7'd30, 7'd6,  7'd22, 7'd11, 7'd4,  7'd25};

  localparam logic [6:0] PINV [32] = '{
    7'd9,  7'd17, 7'd23, 7'd31, 7'd13, 7'd28, 7'd2,  7'd18,
    7'd24, 7'd16, 7'd30, 7'd6,  7'd26, 7'd20, 7'd10, 7'd1,
    7'd8,  7'd14, 7'd25, 7'd3,  7'd4,  7'd29, 7'd11, 7'd19,
    7'd32, 7'd12, 7'd22, 7'd7,  7'd5,  7'd27, 7'd15, 7'd21};

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

  // table entry t names bit t counted from the msb, starting at 1
  function automatic logic [63:0] ip_perm(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) y[63-i] = x[64-int'(IP[i])];
    return y;
  endfunction

  function automatic logic [63:0] fp_perm(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) y[63-i] = x[64-int'(FP[i])];
    return y;
  endfunction

  function automatic logic [47:0] expand(input logic [31:0] x);
    logic [47:0] y;
    for (int i = 0; i < 48; i++) y[47-i] = x[32-int'(EXP[i])];
    return y;
  endfunction

  function automatic logic [47:0] pc2_sel(input logic [55:0] x);
    logic [47:0] y;
    for (int i = 0; i < 48; i++) y[47-i] = x[56-int'(PC2[i])];
    return y;
  endfunction

  function automatic logic [31:0] p_perm(input logic [31:0] x, input logic inv);
    logic [31:0] y;
    for (int i = 0; i < 32; i++) begin
      y[31-i] = inv ? x[32-int'(PINV[i])] : x[32-int'(PT[i])];
    end
    return y;
  endfunction

  // eight s-boxes, row from the outer bits, column from the inner four
  function automatic logic [31:0] sbox_sub(input logic [47:0] x);
    logic [31:0] y;
    logic [5:0]  idx;
    for (int j = 0; j < 8; j++) begin
      idx = {x[47-6*j], x[42-6*j], x[46-6*j -: 4]};
      y[31-4*j -: 4] = SBOX[j][idx];
    end
    return y;
  endfunction

  // rotate one 28-bit half toward the msb by 0 to 28 places
  function automatic logic [27:0] rotl_half(input logic [27:0] h, input logic [4:0] amt);
    logic [55:0] t;
    t = {h, h} << amt;
    return t[55:28];
  endfunction

  function automatic logic [55:0] rotl_cd(input logic [55:0] cd, input logic [4:0] amt);
    return {rotl_half(cd[55:28], amt), rotl_half(cd[27:0], amt)};
  endfunction

  function automatic logic [55:0] rotr_cd(input logic [55:0] cd, input logic [1:0] amt);
    return {rotl_half(cd[55:28], 5'd28 - {3'b0, amt}),
            rotl_half(cd[27:0], 5'd28 - {3'b0, amt})};
  endfunction

  // total shift of the first n schedule steps
  function automatic logic [4:0] cum_rot(input logic [4:0] n);
    logic [4:0] s;
    s = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (i < int'(n)) s = s + {3'b0, ROT[i]};
    end
    return s;
  endfunction

endpackage
`default_nettype wire

[hdl/drrc_prep.sv]
// entry stage: initial permutation and key pre-rotation for reverse order
`default_nettype none
module drrc_prep (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire drrc_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  input  wire logic [63:0]     in_block,
  input  wire logic [55:0]     in_key,
  output logic                 in_ready,
  output logic                 out_valid,
  output drrc_pkg::stage_t     out_data,
  input  wire logic            out_ready
);

  logic             valid_r;
  drrc_pkg::stage_t data_r;
  drrc_pkg::stage_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // reverse order starts from the key of the last used schedule step
  always_comb begin
    data_nxt.lr = drrc_pkg::ip_perm(in_block);
    data_nxt.cd = cfg.rev ? drrc_pkg::rotl_cd(in_key, drrc_pkg::cum_rot(cfg.rounds))
                          : in_key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/drrc_round.sv]
// one feistel round with its key schedule step, registered
`default_nettype none
module drrc_round #(
  parameter int STAGE = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire drrc_pkg::cfg_t    cfg,
  input  wire logic              in_valid,
  input  wire drrc_pkg::stage_t  in_data,
  output logic                   in_ready,
  output logic                   out_valid,
  output drrc_pkg::stage_t       out_data,
  input  wire logic              out_ready
);

  localparam logic [4:0] STG = 5'(STAGE);

  logic             valid_r;
  drrc_pkg::stage_t data_r;
  drrc_pkg::stage_t data_nxt;
  logic             active;
  logic [3:0]       ridx;
  logic [55:0]      kcd;
  logic [55:0]      cd_next;
  logic [47:0]      pre;
  logic [31:0]      fb;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  assign active = STG < cfg.rounds;
  assign ridx   = 4'(cfg.rounds - STG - 5'd1);

  // key for this round and the halves handed to the next one
  always_comb begin
    if (cfg.rev) begin
      kcd     = in_data.cd;
      cd_next = drrc_pkg::rotr_cd(in_data.cd, drrc_pkg::ROT[ridx]);
    end else begin
      kcd     = drrc_pkg::rotl_cd(in_data.cd, {3'b0, drrc_pkg::ROT[STAGE]});
      cd_next = kcd;
    end
  end

  // round function and half swap
  always_comb begin
    pre = drrc_pkg::expand(in_data.lr[31:0]) ^ drrc_pkg::pc2_sel(kcd);
    fb  = drrc_pkg::p_perm(drrc_pkg::sbox_sub(pre), cfg.pinv);
    if (active) begin
      data_nxt.lr = {in_data.lr[31:0], in_data.lr[63:32] ^ fb};
      data_nxt.cd = cd_next;
    end else begin
      data_nxt = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

[hdl/drrc_final.sv]
// exit stage: final permutation into the output register
`default_nettype none
module drrc_final (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire drrc_pkg::stage_t  in_data,
  output logic                   in_ready,
  output logic                   out_valid,
  output logic [63:0]            out_block,
  input  wire logic              out_ready
);

  logic        valid_r;
  logic [63:0] block_r;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_block = block_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      block_r <= drrc_pkg::fp_perm(in_data.lr);
    end
  end

endmodule
`default_nettype wire

[hdl/des_reduced_round_cipher.sv]
// top level of the reduced-round block cipher pipeline
//
//  channel  direction  payload
//  in_      slave      tdata[63:0] block_in, tdata[119:64] key_halves
//  out_     master     tdata[63:0] block_out
//  cfg_     write      index 0 round_count, 1 reverse_keys, 2 inverse_perm_mode
//
// one word per cycle while out_tready stays high; registered stages in order:
// entry stage, one stage per round, final permutation stage.
// rounds past the programmed count pass the word through unchanged.
// reset is synchronous, clears all valid bits and loads the register defaults.
// each stage takes a word when it is empty or its successor takes one, so a
// stall at the output fills bubbles before it reaches the input.
`default_nettype none
module des_reduced_round_cipher #(
  parameter int MAX_ROUNDS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [119:0]  in_tdata,   // block_in, key_halves
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [63:0]        out_tdata,  // block_out
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [4:0]    cfg_data
);

  localparam logic [4:0] MAX_R = 5'(MAX_ROUNDS);

  logic [4:0]     round_count_r;
  logic           reverse_keys_r;
  logic           inverse_perm_mode_r;
  drrc_pkg::cfg_t cfg;

  logic             st_valid [MAX_ROUNDS+1];
  logic             st_ready [MAX_ROUNDS+1];
  drrc_pkg::stage_t st_data  [MAX_ROUNDS+1];
  logic             fin_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r       <= 5'd16;
      reverse_keys_r      <= 1'b0;
      inverse_perm_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        drrc_pkg::REG_ROUNDS: round_count_r       <= cfg_data;
        drrc_pkg::REG_REV:    reverse_keys_r      <= cfg_data[0];
        drrc_pkg::REG_PINV:   inverse_perm_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp round count to one .. MAX_ROUNDS
  always_comb begin
    if (round_count_r == 5'd0)      cfg.rounds = 5'd1;
    else if (round_count_r > MAX_R) cfg.rounds = MAX_R;
    else                            cfg.rounds = round_count_r;
    cfg.rev  = reverse_keys_r;
    cfg.pinv = inverse_perm_mode_r;
  end

  drrc_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_block  (in_tdata[63:0]),
    .in_key    (in_tdata[119:64]),
    .in_ready  (in_tready),
    .out_valid (st_valid[0]),
    .out_data  (st_data[0]),
    .out_ready (st_ready[0])
  );

  // round stages
  for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_round
    drrc_round #(.STAGE(k)) u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (cfg),
      .in_valid  (st_valid[k]),
      .in_data   (st_data[k]),
      .in_ready  (st_ready[k]),
      .out_valid (st_valid[k+1]),
      .out_data  (st_data[k+1]),
      .out_ready (st_ready[k+1])
    );
  end

  assign st_ready[MAX_ROUNDS] = fin_ready;

  drrc_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (st_valid[MAX_ROUNDS]),
    .in_data   (st_data[MAX_ROUNDS]),
    .in_ready  (fin_ready),
    .out_valid (out_tvalid),
    .out_block (out_tdata),
    .out_ready (out_tready)
  );

endmodule
`default_nettype wire

[hdl/drrc_checker.sv]
// port-level checks for the cipher pipeline, bound to the top level
`default_nettype none
module drrc_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_tready,
  input wire logic          out_tvalid,
  input wire logic          out_tready,
  input wire logic [63:0]   out_tdata
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

  // an empty output stage lets the whole pipeline advance
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

  // a taken result frees a slot all the way back to the input
  a_ready_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

endmodule

bind des_reduced_round_cipher drrc_checker u_drrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
